// ----- design/indexed_list_insert_remove_find_defines.svh -----
// Assertion macros used by the checker file of the indexed list.
`ifndef INDEXED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define ILST_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ILST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ilst_pkg.sv -----
// Types and codes shared by the indexed list modules.
package ilst_pkg;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_FIND   = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_SET    = 3'd4,
        KIND_READ   = 3'd5,
        KIND_CLEAR  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         position;
        logic signed [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic signed [4:0]  found_index;
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         length;
    } t_rsp;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] value;
    } t_cell_ctrl;

    localparam logic [4:0] FOUND_NONE = 5'h1F;

endpackage

// ----- design/ilst_chan.sv -----
// Valid/ready channel interface carrying one request or one result.
interface ilst_chan #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/ilst_cell.sv -----
// One storage cell of the list chain, holding the word at a fixed index.
module ilst_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                                  i_clk,
    input  ilst_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]            i_pos,
    input  logic [31:0]                           i_left,
    input  logic [31:0]                           i_right,
    output logic [31:0]                           o_data
);
    import ilst_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [31:0] r_data;
    logic [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_WRITE: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_ctrl.value;
                end
            end
            OP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_ctrl.value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            OP_ROTATE: begin
                n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// ----- design/indexed_list_insert_remove_find.sv -----
// Top level of the indexed list: request decode, scan control and the cell chain.
//
//  Channel | Dir | Payload                                      | Handshake
//  i_req   | in  | kind, position, item_value                   | valid/ready
//  o_rsp   | out | found_index, read_value, status, length      | valid/ready
//
// Append, remove, insert, set, clear and every flagged request complete in the
// cycle they are accepted, so these can follow one another in every cycle while
// the output is not stalled. Find and an in-range read rotate the cell ring once
// and take no new request until that rotation ends and the result is loaded.
// Reset clears the word count; the stored words are undefined until written.
// A stalled result waits in the output register and blocks a new request only
// while the register is full and not being taken.
module indexed_list_insert_remove_find #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ilst_chan.sink         i_req,
    ilst_chan.source       o_rsp
);
    import ilst_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX   = IW'(DEPTH - 1);

    t_state         r_state;
    t_state         n_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [IW-1:0]  r_k;
    logic [IW-1:0]  n_k;
    logic           r_scan_find;
    logic           n_scan_find;
    logic [31:0]    r_scan_val;
    logic [31:0]    n_scan_val;
    logic [IW-1:0]  r_scan_pos;
    logic [IW-1:0]  n_scan_pos;
    logic           r_hit;
    logic           n_hit;
    logic [IW-1:0]  r_hit_idx;
    logic [IW-1:0]  n_hit_idx;
    logic [31:0]    r_rd;
    logic [31:0]    n_rd;
    logic           r_out_valid;
    logic           n_out_valid;
    t_rsp           r_out;
    t_rsp           n_out;

    t_req           w_req;
    logic           w_accept;
    logic           w_load;
    logic           w_scan_start;
    logic           w_scan_last;
    logic [8:0]     w_pos9;
    logic [8:0]     w_cnt9;
    logic           w_pos_ge;
    logic           w_pos_gt;
    logic           w_full;
    logic [CW-1:0]  w_pos_eff;
    logic [1:0]     w_status;
    logic [IW+4:0]  w_found_ext;
    logic [CW+4:0]  w_len_ext;
    t_cell_ctrl     w_ctrl;
    logic [CW-1:0]  w_cell_pos;
    logic [31:0]    w_data [DEPTH];

    assign i_req.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_req       = i_req.payload;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pos9      = {1'b0, w_req.position};
    assign w_cnt9      = 9'(r_count);
    assign w_pos_ge    = w_pos9 >= w_cnt9;
    assign w_pos_gt    = w_pos9 > w_cnt9;
    assign w_full      = r_count == FULL_COUNT;
    assign w_pos_eff   = w_pos_gt ? r_count : CW'(w_req.position);
    assign w_scan_last = (r_state == S_SCAN) && (r_k == LAST_IDX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_scan_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl.op    = OP_HOLD;
        w_ctrl.value = w_req.item_value;
        w_cell_pos   = CW'(w_req.position);
        w_status     = ST_DONE;
        w_load       = 1'b0;
        w_scan_start = 1'b0;
        n_count      = r_count;
        n_k          = r_k;
        n_scan_find  = r_scan_find;
        n_scan_val   = r_scan_val;
        n_scan_pos   = r_scan_pos;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_rd         = r_rd;

        if (r_state == S_SCAN) begin
            w_ctrl.op = OP_ROTATE;
            n_k       = r_k + 1'b1;
            if (r_scan_find && !r_hit && (CW'(r_k) < r_count) &&
                    (w_data[0] == r_scan_val)) begin
                n_hit     = 1'b1;
                n_hit_idx = r_k;
            end
            if (!r_scan_find && (r_k == r_scan_pos)) begin
                n_rd = w_data[0];
            end
            w_load = w_scan_last;
        end else if (w_accept) begin
            w_load = 1'b1;
            unique case (t_kind'(w_req.kind))
                KIND_APPEND: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctrl.op  = OP_WRITE;
                        w_cell_pos = r_count;
                        n_count    = r_count + 1'b1;
                    end
                end
                KIND_FIND: begin
                    w_load       = 1'b0;
                    w_scan_start = 1'b1;
                    n_scan_find  = 1'b1;
                end
                KIND_REMOVE: begin
                    if (w_pos_ge) begin
                        w_status = ST_RANGE;
                    end else begin
                        w_ctrl.op = OP_REMOVE;
                        n_count   = r_count - 1'b1;
                    end
                end
                KIND_INSERT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctrl.op  = OP_INSERT;
                        w_cell_pos = w_pos_eff;
                        n_count    = r_count + 1'b1;
                    end
                end
                KIND_SET: begin
                    if (w_pos_ge) begin
                        w_status = ST_RANGE;
                    end else begin
                        w_ctrl.op = OP_WRITE;
                    end
                end
                KIND_READ: begin
                    if (w_pos_ge) begin
                        w_status = ST_RANGE;
                    end else begin
                        w_load       = 1'b0;
                        w_scan_start = 1'b1;
                        n_scan_find  = 1'b0;
                    end
                end
                KIND_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    w_status = ST_DONE;
                end
            endcase
            if (w_scan_start) begin
                n_k        = '0;
                n_scan_val = w_req.item_value;
                n_scan_pos = w_req.position[IW-1:0];
                n_hit      = 1'b0;
                n_hit_idx  = '0;
                n_rd       = '0;
            end
        end

        w_found_ext = (IW + 5)'(n_hit_idx);
        w_len_ext   = (CW + 5)'(n_count);
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out.length = w_len_ext[4:0];
            n_out.status = w_status;
            if (r_state == S_SCAN) begin
                n_out.found_index = (r_scan_find && n_hit) ? w_found_ext[4:0] : FOUND_NONE;
                n_out.read_value  = r_scan_find ? 32'sd0 : n_rd;
            end else begin
                n_out.found_index = FOUND_NONE;
                n_out.read_value  = 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_find <= n_scan_find;
        r_scan_val  <= n_scan_val;
        r_scan_pos  <= n_scan_pos;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_rd        <= n_rd;
        r_out       <= n_out;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        ilst_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_cell_pos),
            .i_left  (w_data[(gi + DEPTH - 1) % DEPTH]),
            .i_right (w_data[(gi + 1) % DEPTH]),
            .o_data  (w_data[gi])
        );
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
endmodule

// ----- design/ilst_checker.sv -----
// Port-level checker for the indexed list and its bind to the top level.
`include "indexed_list_insert_remove_find_defines.svh"

module ilst_checker #(
    parameter int DEPTH = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input ilst_pkg::t_rsp i_out
);
    import ilst_pkg::*;

    logic       r_have_prev;
    logic [4:0] r_prev_len;
    logic       w_fire;

    assign w_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (w_fire) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_prev_len <= i_out.length;
        end
    end

    `ILST_ASSERT_RST(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out), "Stalled result changed or vanished")
    `ILST_ASSERT_RST(a_len_step, i_clk, i_rst_n, w_fire && r_have_prev |-> (i_out.length == r_prev_len) || (i_out.length == 5'(r_prev_len + 5'd1)) || (i_out.length == 5'(r_prev_len - 5'd1)) || (i_out.length == 5'd0), "Length moved by more than one word")
    `ILST_ASSERT_RST(a_full_len, i_clk, i_rst_n, i_out_valid && (i_out.status == ST_FULL) |-> i_out.length == 5'(DEPTH), "List full flagged below capacity")
    `ILST_ASSERT_RST(a_flag_clean, i_clk, i_rst_n, i_out_valid && (i_out.status != ST_DONE) |-> (i_out.read_value == 32'sd0) && (i_out.found_index == -5'sd1), "Flagged request returned data")
    `ILST_ASSERT_RST(a_read_excl, i_clk, i_rst_n, i_out_valid && (i_out.read_value != 32'sd0) |-> (i_out.found_index == -5'sd1), "Read data and find index both present")
endmodule

bind indexed_list_insert_remove_find ilst_checker #(
    .DEPTH (DEPTH)
) u_ilst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out       (o_rsp.payload)
);
